/* src/tpg_pkg.sv */
// Shared constants, codes and types of the RGB565 test pattern generator.
`default_nettype none

package tpg_pkg;

   localparam int COORD_W  = 9;
   localparam int PANEL_W  = 10;
   localparam int CELL_W   = 9;
   localparam int COLOR_W  = 16;
   localparam int MODE_W   = 3;
   localparam int INDEX_W  = 3;
   localparam int T_W      = 8;
   localparam int CHAN_W   = 6;
   localparam int NCHAN    = 3;
   localparam int PROD_W   = CHAN_W + T_W;

   localparam int DIV_NUM_W = COORD_W + T_W;
   localparam int DIV_DEN_W = PANEL_W;
   localparam int DIV_STEP  = 2;
   localparam int TAG_W     = 2 * COORD_W + 1;

   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;

   // floor(v/3) == (v*683) >> 11 for every 10-bit v
   localparam logic [PANEL_W-1:0] RECIP3       = 10'd683;
   localparam int                 RECIP3_SHIFT = 11;

   localparam logic [MODE_W-1:0] MODE_COLUMNS   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ROWS      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CHECKER   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DIAGONAL  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CROSSHAIR = 3'd4;
   localparam logic [MODE_W-1:0] MODE_GRADIENT  = 3'd5;

   localparam logic [INDEX_W-1:0] REG_PATTERN_MODE = 3'd0;
   localparam logic [INDEX_W-1:0] REG_PANEL_WIDTH  = 3'd1;
   localparam logic [INDEX_W-1:0] REG_PANEL_HEIGHT = 3'd2;
   localparam logic [INDEX_W-1:0] REG_CELL_SIZE    = 3'd3;
   localparam logic [INDEX_W-1:0] REG_STRIPE_WIDTH = 3'd4;
   localparam logic [INDEX_W-1:0] REG_LINE_COLOR   = 3'd5;
   localparam logic [INDEX_W-1:0] REG_START_COLOR  = 3'd6;
   localparam logic [INDEX_W-1:0] REG_END_COLOR    = 3'd7;

   localparam logic [MODE_W-1:0]  RST_PATTERN_MODE = MODE_COLUMNS;
   localparam logic [PANEL_W-1:0] RST_PANEL_WIDTH  = 10'd480;
   localparam logic [PANEL_W-1:0] RST_PANEL_HEIGHT = 10'd320;
   localparam logic [CELL_W-1:0]  RST_CELL_SIZE    = 9'd16;
   localparam logic [PANEL_W-1:0] RST_STRIPE_WIDTH = 10'd16;
   localparam logic [COLOR_W-1:0] RST_LINE_COLOR   = 16'hFFFF;
   localparam logic [COLOR_W-1:0] RST_START_COLOR  = 16'h0000;
   localparam logic [COLOR_W-1:0] RST_END_COLOR    = 16'hFFFF;

   localparam logic [COLOR_W-1:0] COLOR_RED     = 16'hF800;
   localparam logic [COLOR_W-1:0] COLOR_GREEN   = 16'h07E0;
   localparam logic [COLOR_W-1:0] COLOR_BLUE    = 16'h001F;
   localparam logic [COLOR_W-1:0] COLOR_WHITE   = 16'hFFFF;
   localparam logic [COLOR_W-1:0] COLOR_BLACK   = 16'h0000;
   localparam logic [COLOR_W-1:0] COLOR_CYAN    = 16'h07FF;
   localparam logic [COLOR_W-1:0] COLOR_MAGENTA = 16'hF81F;

   localparam int CH_B = 0;
   localparam int CH_G = 1;
   localparam int CH_R = 2;

   // Values that follow from the configuration registers alone.
   typedef struct packed {
      logic [DIV_DEN_W-1:0]          den_a;
      logic [DIV_DEN_W-1:0]          den_b;
      logic [PANEL_W-1:0]            third_w;
      logic [PANEL_W-1:0]            two_third_w;
      logic [PANEL_W-1:0]            third_h;
      logic [PANEL_W-1:0]            two_third_h;
      logic [PANEL_W-1:0]            half_w;
      logic [PANEL_W-1:0]            half_h;
      logic [COLOR_W-1:0]            line_color;
      logic [NCHAN-1:0][CHAN_W-1:0]  ch_base;
      logic [NCHAN-1:0][CHAN_W-1:0]  ch_diff;
      logic [NCHAN-1:0]              ch_up;
   } cfg_type;

endpackage

`default_nettype wire

/* src/rgb565_test_pattern_generator.sv */
// Words pass input, prep, divider, multiply and output registers to the rsp ports.
// Throughput: one pixel per clock while rsp is not stalled; depth is set by the 17-bit divider
// (pipelined, two quotient bits per stage, nine stages) plus input, prep, multiply, output.
// Bubbles close up: each stage advances when it or any later stage has room.
// Reset: synchronous, active high; clears all valid bits and loads register defaults.
`default_nettype none

module rgb565_test_pattern_generator import tpg_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // pixel request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [COORD_W-1:0] req_pixel_x,
   input  wire logic [COORD_W-1:0] req_pixel_y,
   input  wire logic               req_frame_last_in,
   // color response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [COLOR_W-1:0] rsp_pixel_color,
   output logic                    rsp_frame_last_out,
   // configuration write port
   input  wire logic               csr_write_en,
   input  wire logic [INDEX_W-1:0] csr_index,
   input  wire logic [COLOR_W-1:0] csr_data
);

   localparam int DIV_STAGES = (DIV_NUM_W + DIV_STEP - 1) / DIV_STEP;
   localparam int ST_PREP    = 1;
   localparam int ST_DIV0    = 2;
   localparam int ST_MUL     = DIV_STAGES + 2;
   localparam int ST_OUT     = DIV_STAGES + 3;
   localparam int NSTG       = DIV_STAGES + 4;

   // ------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------
   logic [MODE_W-1:0] mode;
   cfg_type           cfg;

   tpg_cfg #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .mode         (mode),
      .cfg          (cfg)
   );

   // ------------------------------------------------------------------
   // Pipeline control: one valid bit per stage. A stage may take a new
   // word when any stage at or after it is empty, or the output drains.
   // ------------------------------------------------------------------
   logic [NSTG-1:0] v_ff, v_in;
   logic [NSTG-1:0] ready;
   logic [NSTG-1:0] ld;

   for (genvar k = 0; k < NSTG; k++) begin : g_ctl
      assign ready[k] = !rsp_stall || !(&v_ff[NSTG-1:k]);
      if (k == 0) begin : g_head
         assign ld[k]   = ready[k] && req_valid;
         assign v_in[k] = ready[k] ? req_valid : v_ff[k];
      end else begin : g_body
         assign ld[k]   = ready[k] && v_ff[k-1];
         assign v_in[k] = ready[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = !ready[0];

   // ------------------------------------------------------------------
   // Stage 0: capture the request word
   // ------------------------------------------------------------------
   logic [COORD_W-1:0] x0_ff, x0_in, y0_ff, y0_in;
   logic               last0_ff, last0_in;

   assign x0_in    = req_pixel_x;
   assign y0_in    = req_pixel_y;
   assign last0_in = req_frame_last_in;

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         x0_ff    <= x0_in;
         y0_ff    <= y0_in;
         last0_ff <= last0_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: pick the dividends for the active pattern.
   //   checkerboard: x / cell and y / cell
   //   diagonal:     (x + y) / stripe
   //   gradient:     (x * 255) / max(w-1, 1)
   // ------------------------------------------------------------------
   logic [DIV_NUM_W-1:0] num_a1_ff, num_a1_in, num_b1_ff, num_b1_in;
   logic [TAG_W-1:0]     tag1_ff, tag1_in;

   always_comb begin
      if (mode == MODE_GRADIENT) begin
         num_a1_in = DIV_NUM_W'({x0_ff, {T_W{1'b0}}}) - DIV_NUM_W'(x0_ff);
      end else if (mode == MODE_DIAGONAL) begin
         num_a1_in = DIV_NUM_W'(x0_ff) + DIV_NUM_W'(y0_ff);
      end else begin
         num_a1_in = DIV_NUM_W'(x0_ff);
      end
      num_b1_in = DIV_NUM_W'(y0_ff);
      tag1_in   = {x0_ff, y0_ff, last0_ff};
   end

   always_ff @(posedge clock) begin
      if (ld[ST_PREP]) begin
         num_a1_ff <= num_a1_in;
         num_b1_ff <= num_b1_in;
         tag1_ff   <= tag1_in;
      end
   end

   // ------------------------------------------------------------------
   // Stages 2 .. 2+DIV_STAGES-1: divider; coordinates ride along as a tag
   // ------------------------------------------------------------------
   logic [DIV_NUM_W-1:0] quo_a, quo_b;
   logic [TAG_W-1:0]     tag_d;

   tpg_div_pipe #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W),
      .STEP  (DIV_STEP),
      .TAG_X (TAG_W)
   ) u_div (
      .clock   (clock),
      .advance (ld[ST_DIV0 +: DIV_STAGES]),
      .num_a   (num_a1_ff),
      .num_b   (num_b1_ff),
      .den_a   (cfg.den_a),
      .den_b   (cfg.den_b),
      .tag_in  (tag1_ff),
      .quo_a   (quo_a),
      .quo_b   (quo_b),
      .tag_out (tag_d)
   );

   // ------------------------------------------------------------------
   // Multiply stage: flat color for the simple patterns, and the
   // gradient channel products |b-a| * t
   // ------------------------------------------------------------------
   function automatic logic [COLOR_W-1:0] thirds(input logic [PANEL_W-1:0] pos,
                                                 input logic [PANEL_W-1:0] third,
                                                 input logic [PANEL_W-1:0] two_third);
      if (pos < third) begin
         thirds = COLOR_RED;
      end else if (pos < two_third) begin
         thirds = COLOR_GREEN;
      end else begin
         thirds = COLOR_BLUE;
      end
   endfunction

   logic [COORD_W-1:0]            xd, yd;
   logic                          lastd;
   logic [T_W-1:0]                t_sat;
   logic [NCHAN-1:0][PROD_W-1:0]  prod_ff, prod_in;
   logic [COLOR_W-1:0]            flat_ff, flat_in;
   logic                          last_m_ff, last_m_in;

   assign {xd, yd, lastd} = tag_d;

   always_comb begin
      // past the right edge the quotient exceeds 255: hold the end color
      t_sat = (|quo_a[DIV_NUM_W-1:T_W]) ? {T_W{1'b1}} : quo_a[T_W-1:0];
      for (int c = 0; c < NCHAN; c++) begin
         prod_in[c] = {{T_W{1'b0}}, cfg.ch_diff[c]} * {{CHAN_W{1'b0}}, t_sat};
      end
      unique case (mode)
         MODE_COLUMNS:   flat_in = thirds(PANEL_W'(xd), cfg.third_w, cfg.two_third_w);
         MODE_ROWS:      flat_in = thirds(PANEL_W'(yd), cfg.third_h, cfg.two_third_h);
         MODE_CHECKER:   flat_in = (quo_a[0] ^ quo_b[0]) ? COLOR_WHITE : COLOR_BLACK;
         MODE_DIAGONAL:  flat_in = quo_a[0] ? COLOR_MAGENTA : COLOR_CYAN;
         MODE_CROSSHAIR: flat_in = (PANEL_W'(xd) == cfg.half_w || PANEL_W'(yd) == cfg.half_h) ?
                                   cfg.line_color : COLOR_BLACK;
         default:        flat_in = COLOR_BLACK;
      endcase
      last_m_in = lastd;
   end

   always_ff @(posedge clock) begin
      if (ld[ST_MUL]) begin
         prod_ff   <= prod_in;
         flat_ff   <= flat_in;
         last_m_ff <= last_m_in;
      end
   end

   // ------------------------------------------------------------------
   // Output stage: divide products by 255, apply to the start color and
   // pick gradient or flat color
   // ------------------------------------------------------------------
   // floor(p/255) == (p + (p>>8) + 1) >> 8 for p up to 63*255
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] p);
      logic [PROD_W-1:0] s;
      s      = p + (p >> T_W) + PROD_W'(1);
      div255 = s[PROD_W-1:T_W];
   endfunction

   logic [NCHAN-1:0][CHAN_W-1:0] blend;
   logic [COLOR_W-1:0]           color_ff, color_in;
   logic                         last_o_ff, last_o_in;

   always_comb begin
      for (int c = 0; c < NCHAN; c++) begin
         blend[c] = cfg.ch_up[c] ? cfg.ch_base[c] + div255(prod_ff[c])
                                 : cfg.ch_base[c] - div255(prod_ff[c]);
      end
      if (mode == MODE_GRADIENT) begin
         color_in = {blend[CH_R][4:0], blend[CH_G], blend[CH_B][4:0]};
      end else begin
         color_in = flat_ff;
      end
      last_o_in = last_m_ff;
   end

   always_ff @(posedge clock) begin
      if (ld[ST_OUT]) begin
         color_ff  <= color_in;
         last_o_ff <= last_o_in;
      end
   end

   assign rsp_valid          = v_ff[ST_OUT];
   assign rsp_pixel_color    = color_ff;
   assign rsp_frame_last_out = last_o_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   // the request side only stalls when every stage holds a word
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&v_ff) && rsp_stall))
      else $error("request stalled while the pipeline had room");

   // a word blocked in the prep stage stays put with its dividend intact
   a_prep_holds: assert property (@(posedge clock) disable iff (reset)
      (v_ff[ST_PREP] && !ready[ST_DIV0]) |=> (v_ff[ST_PREP] && $stable(num_a1_ff)))
      else $error("prep stage word lost or changed under stall");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

/* src/tpg_cfg.sv */
// Configuration registers and the registered values derived from them.
`default_nettype none

module tpg_cfg import tpg_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_en,
   input  wire logic [INDEX_W-1:0] csr_index,
   input  wire logic [COLOR_W-1:0] csr_data,
   output logic      [MODE_W-1:0]  mode,
   output cfg_type                 cfg
);

   localparam int PANEL_MAX = 2 ** PANEL_W - 1;
   localparam int CLAMP_W   = (MAX_WIDTH > PANEL_MAX) ? PANEL_MAX : MAX_WIDTH;
   localparam int CLAMP_H   = (MAX_HEIGHT > PANEL_MAX) ? PANEL_MAX : MAX_HEIGHT;
   localparam int MUL3_W    = 2 * PANEL_W;

   logic [MODE_W-1:0]  mode_ff,   mode_in;
   logic [PANEL_W-1:0] width_ff,  width_in;
   logic [PANEL_W-1:0] height_ff, height_in;
   logic [CELL_W-1:0]  cell_ff,   cell_in;
   logic [PANEL_W-1:0] stripe_ff, stripe_in;
   logic [COLOR_W-1:0] line_ff,   line_in;
   logic [COLOR_W-1:0] start_ff,  start_in;
   logic [COLOR_W-1:0] end_ff,    end_in;
   cfg_type            derived_ff, derived_in;

   logic [PANEL_W-1:0]           w_eff, h_eff, cell_eff, stripe_eff, grad_den;
   logic [MUL3_W-1:0]            w_mul3, h_mul3;
   logic [NCHAN-1:0][CHAN_W-1:0] ch_a, ch_b;

   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      cell_in   = cell_ff;
      stripe_in = stripe_ff;
      line_in   = line_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_PATTERN_MODE: mode_in   = csr_data[MODE_W-1:0];
            REG_PANEL_WIDTH:  width_in  = csr_data[PANEL_W-1:0];
            REG_PANEL_HEIGHT: height_in = csr_data[PANEL_W-1:0];
            REG_CELL_SIZE:    cell_in   = csr_data[CELL_W-1:0];
            REG_STRIPE_WIDTH: stripe_in = csr_data[PANEL_W-1:0];
            REG_LINE_COLOR:   line_in   = csr_data;
            REG_START_COLOR:  start_in  = csr_data;
            REG_END_COLOR:    end_in    = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= RST_PATTERN_MODE;
         width_ff  <= RST_PANEL_WIDTH;
         height_ff <= RST_PANEL_HEIGHT;
         cell_ff   <= RST_CELL_SIZE;
         stripe_ff <= RST_STRIPE_WIDTH;
         line_ff   <= RST_LINE_COLOR;
         start_ff  <= RST_START_COLOR;
         end_ff    <= RST_END_COLOR;
      end else begin
         mode_ff   <= mode_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         cell_ff   <= cell_in;
         stripe_ff <= stripe_in;
         line_ff   <= line_in;
         start_ff  <= start_in;
         end_ff    <= end_in;
      end
   end

   always_comb begin
      w_eff = (width_ff > PANEL_W'(CLAMP_W)) ? PANEL_W'(CLAMP_W) : width_ff;
      h_eff = (height_ff > PANEL_W'(CLAMP_H)) ? PANEL_W'(CLAMP_H) : height_ff;
      cell_eff   = (cell_ff == '0) ? PANEL_W'(1) : PANEL_W'(cell_ff);
      stripe_eff = (stripe_ff == '0) ? PANEL_W'(1) : stripe_ff;
      grad_den   = (w_eff > PANEL_W'(1)) ? w_eff - PANEL_W'(1) : PANEL_W'(1);
      w_mul3 = MUL3_W'(w_eff) * MUL3_W'(RECIP3);
      h_mul3 = MUL3_W'(h_eff) * MUL3_W'(RECIP3);

      ch_a[CH_R] = {1'b0, start_ff[15:11]};
      ch_a[CH_G] = start_ff[10:5];
      ch_a[CH_B] = {1'b0, start_ff[4:0]};
      ch_b[CH_R] = {1'b0, end_ff[15:11]};
      ch_b[CH_G] = end_ff[10:5];
      ch_b[CH_B] = {1'b0, end_ff[4:0]};

      derived_in.den_b = cell_eff;
      if (mode_ff == MODE_GRADIENT) begin
         derived_in.den_a = grad_den;
      end else if (mode_ff == MODE_DIAGONAL) begin
         derived_in.den_a = stripe_eff;
      end else begin
         derived_in.den_a = cell_eff;
      end
      derived_in.third_w     = PANEL_W'(w_mul3 >> RECIP3_SHIFT);
      derived_in.two_third_w = PANEL_W'(w_mul3 >> RECIP3_SHIFT) << 1;
      derived_in.third_h     = PANEL_W'(h_mul3 >> RECIP3_SHIFT);
      derived_in.two_third_h = PANEL_W'(h_mul3 >> RECIP3_SHIFT) << 1;
      derived_in.half_w      = w_eff >> 1;
      derived_in.half_h      = h_eff >> 1;
      derived_in.line_color  = line_ff;
      for (int c = 0; c < NCHAN; c++) begin
         derived_in.ch_base[c] = ch_a[c];
         derived_in.ch_up[c]   = (ch_b[c] >= ch_a[c]);
         derived_in.ch_diff[c] = (ch_b[c] >= ch_a[c]) ? ch_b[c] - ch_a[c] : ch_a[c] - ch_b[c];
      end
   end

   always_ff @(posedge clock) begin
      derived_ff <= derived_in;
   end

   assign mode = mode_ff;
   assign cfg  = derived_ff;

endmodule

`default_nettype wire

/* src/tpg_div_pipe.sv */
// Two-lane pipelined restoring divider, up to STEP quotient bits per stage.
`default_nettype none

module tpg_div_pipe import tpg_pkg::*; #(
   parameter int NUM_W = DIV_NUM_W,
   parameter int DEN_W = DIV_DEN_W,
   parameter int STEP  = DIV_STEP,
   parameter int TAG_X = TAG_W,
   localparam int STAGES = (NUM_W + STEP - 1) / STEP
) (
   input  wire logic              clock,
   input  wire logic [STAGES-1:0] advance,
   input  wire logic [NUM_W-1:0]  num_a,
   input  wire logic [NUM_W-1:0]  num_b,
   input  wire logic [DEN_W-1:0]  den_a,
   input  wire logic [DEN_W-1:0]  den_b,
   input  wire logic [TAG_X-1:0]  tag_in,
   output logic      [NUM_W-1:0]  quo_a,
   output logic      [NUM_W-1:0]  quo_b,
   output logic      [TAG_X-1:0]  tag_out
);

   localparam int W = DEN_W + NUM_W;

   // remainder in the upper DEN_W bits, dividend shifting out / quotient shifting in below
   function automatic logic [W-1:0] div_step(input logic [W-1:0]     work,
                                             input logic [DEN_W-1:0] den);
      logic [W:0]     sh;
      logic [DEN_W:0] hi;
      sh = {work, 1'b0};
      hi = sh[W:NUM_W];
      if (hi >= {1'b0, den}) begin
         hi    = hi - {1'b0, den};
         sh[0] = 1'b1;
      end
      div_step = {hi[DEN_W-1:0], sh[NUM_W-1:0]};
   endfunction

   logic [W-1:0]     work_a_ff [STAGES];
   logic [W-1:0]     work_b_ff [STAGES];
   logic [W-1:0]     work_a_in [STAGES];
   logic [W-1:0]     work_b_in [STAGES];
   logic [TAG_X-1:0] tag_ff    [STAGES];
   logic [TAG_X-1:0] tag_pipe_in [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      localparam int LEFT  = NUM_W - k * STEP;
      localparam int NSTEP = (LEFT < STEP) ? LEFT : STEP;

      logic [W-1:0] chain_a [NSTEP+1];
      logic [W-1:0] chain_b [NSTEP+1];

      if (k == 0) begin : g_first
         assign chain_a[0]     = {{DEN_W{1'b0}}, num_a};
         assign chain_b[0]     = {{DEN_W{1'b0}}, num_b};
         assign tag_pipe_in[k] = tag_in;
      end else begin : g_next
         assign chain_a[0]     = work_a_ff[k-1];
         assign chain_b[0]     = work_b_ff[k-1];
         assign tag_pipe_in[k] = tag_ff[k-1];
      end

      for (genvar i = 0; i < NSTEP; i++) begin : g_bit
         assign chain_a[i+1] = div_step(chain_a[i], den_a);
         assign chain_b[i+1] = div_step(chain_b[i], den_b);
      end

      assign work_a_in[k] = chain_a[NSTEP];
      assign work_b_in[k] = chain_b[NSTEP];

      always_ff @(posedge clock) begin
         if (advance[k]) begin
            work_a_ff[k] <= work_a_in[k];
            work_b_ff[k] <= work_b_in[k];
            tag_ff[k]    <= tag_pipe_in[k];
         end
      end
   end

   assign quo_a   = work_a_ff[STAGES-1][NUM_W-1:0];
   assign quo_b   = work_b_ff[STAGES-1][NUM_W-1:0];
   assign tag_out = tag_ff[STAGES-1];

endmodule

`default_nettype wire
